### hw/rtl/lsc_pkg.sv
`timescale 1ns / 1ps

package lsc_pkg;

    localparam int ELEM_WIDTH_DEF = 16;
    localparam int VAL_W          = 16;   // significant bits of an element
    localparam int PROD_W         = 64;   // product of four elements
    localparam int DET_W          = 72;   // sum of 24 products
    localparam int FRAC_W         = 16;   // Q16.16 result scaling
    localparam int DIV_W          = DET_W + FRAC_W;
    localparam int NUM_PERMS      = 24;

    typedef enum logic [1:0] {
        CMD_LOAD_MAT = 2'd0,
        CMD_LOAD_VEC = 2'd1,
        CMD_SOLVE    = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    // {odd parity, col for row 0, row 1, row 2, row 3}, lexicographic order
    localparam logic [8:0] PERMS [NUM_PERMS] = '{
        {1'b0, 2'd0, 2'd1, 2'd2, 2'd3}, {1'b1, 2'd0, 2'd1, 2'd3, 2'd2},
        {1'b1, 2'd0, 2'd2, 2'd1, 2'd3}, {1'b0, 2'd0, 2'd2, 2'd3, 2'd1},
        {1'b0, 2'd0, 2'd3, 2'd1, 2'd2}, {1'b1, 2'd0, 2'd3, 2'd2, 2'd1},
        {1'b1, 2'd1, 2'd0, 2'd2, 2'd3}, {1'b0, 2'd1, 2'd0, 2'd3, 2'd2},
        {1'b0, 2'd1, 2'd2, 2'd0, 2'd3}, {1'b1, 2'd1, 2'd2, 2'd3, 2'd0},
        {1'b1, 2'd1, 2'd3, 2'd0, 2'd2}, {1'b0, 2'd1, 2'd3, 2'd2, 2'd0},
        {1'b0, 2'd2, 2'd0, 2'd1, 2'd3}, {1'b1, 2'd2, 2'd0, 2'd3, 2'd1},
        {1'b1, 2'd2, 2'd1, 2'd0, 2'd3}, {1'b0, 2'd2, 2'd1, 2'd3, 2'd0},
        {1'b0, 2'd2, 2'd3, 2'd0, 2'd1}, {1'b1, 2'd2, 2'd3, 2'd1, 2'd0},
        {1'b1, 2'd3, 2'd0, 2'd1, 2'd2}, {1'b0, 2'd3, 2'd0, 2'd2, 2'd1},
        {1'b0, 2'd3, 2'd1, 2'd0, 2'd2}, {1'b1, 2'd3, 2'd1, 2'd2, 2'd0},
        {1'b1, 2'd3, 2'd2, 2'd0, 2'd1}, {1'b0, 2'd3, 2'd2, 2'd1, 2'd0}
    };

    typedef struct packed {
        logic       repl_en;
        logic [1:0] repl_col;
        logic [1:0] row;
        logic [1:0] col;
    } t_rd_req;

endpackage

### hw/rtl/linear_solve_4x4_cramer.sv
`timescale 1ns / 1ps

// Channel   Ports                                     Transfer
// command   i_cmd, i_row, i_col, i_value              start && !busy
// result    o_x0..o_x3, o_singular                    o_valid, one cycle
//
// Loads write the store directly and busy stays low. A solve holds busy
// through the determinant of the matrix and four numerator determinants,
// each followed by a division; a singular matrix ends after the first
// determinant. The determinant unit has one shared multiplier and the
// divider produces one quotient bit per cycle. Reset is synchronous and
// clears both stores. The receiver cannot stall.
module linear_solve_4x4_cramer #(
    parameter int ELEM_WIDTH = lsc_pkg::ELEM_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [1:0]         i_row,
    input  logic [1:0]         i_col,
    input  logic signed [15:0] i_value,
    output logic               o_valid,
    output logic signed [31:0] o_x0,
    output logic signed [31:0] o_x1,
    output logic signed [31:0] o_x2,
    output logic signed [31:0] o_x3,
    output logic               o_singular
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DETA = 4'b0010,
        ST_DETK = 4'b0100,
        ST_DIV  = 4'b1000
    } t_state;

    t_state                                 r_state;
    logic [1:0]                             r_k;
    logic signed [lsc_pkg::DET_W-1:0]       r_den;
    logic [31:0]                            r_x [4];
    logic                                   r_sing;
    logic                                   r_valid;
    logic                                   accept;
    logic                                   we_mat;
    logic                                   we_vec;
    logic                                   det_go;
    logic                                   div_go;
    logic                                   det_done;
    logic                                   div_done;
    logic signed [lsc_pkg::DET_W-1:0]       det;
    logic [31:0]                            quo;
    logic signed [lsc_pkg::VAL_W-1:0]       elem;
    logic [1:0]                             rd_row;
    logic [1:0]                             rd_col;
    lsc_pkg::t_rd_req                       rd;

    assign busy   = r_state != ST_IDLE;
    assign accept = start && !busy;
    assign we_mat = accept && i_cmd == lsc_pkg::CMD_LOAD_MAT;
    assign we_vec = accept && i_cmd == lsc_pkg::CMD_LOAD_VEC;

    assign det_go = (accept && i_cmd == lsc_pkg::CMD_SOLVE)
                 || (r_state == ST_DETA && det_done && det != '0)
                 || (r_state == ST_DIV && div_done && r_k != 2'd3);
    assign div_go = r_state == ST_DETK && det_done;

    assign rd = {r_state == ST_DETK, r_k, rd_row, rd_col};

    lsc_store #(.ELEM_WIDTH(ELEM_WIDTH)) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we_mat (we_mat),
        .i_we_vec (we_vec),
        .i_row    (i_row),
        .i_col    (i_col),
        .i_value  (i_value),
        .i_rd     (rd),
        .o_elem   (elem)
    );

    lsc_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (det_go),
        .i_elem  (elem),
        .o_row   (rd_row),
        .o_col   (rd_col),
        .o_done  (det_done),
        .o_det   (det)
    );

    lsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (det),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_cmd == lsc_pkg::CMD_SOLVE) r_state <= ST_DETA;
                end
                ST_DETA: begin
                    if (det_done) begin
                        r_k <= '0;
                        if (det == '0) begin
                            r_valid <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_DETK;
                        end
                    end
                end
                ST_DETK: begin
                    if (det_done) r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (r_k == 2'd3) begin
                            r_valid <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= ST_DETK;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DETA && det_done) begin
            r_den  <= det;
            r_sing <= det == '0;
            if (det == '0) begin
                for (int i = 0; i < 4; i++) r_x[i] <= 32'hFFFF0000;
            end
        end
        if (r_state == ST_DIV && div_done) r_x[r_k] <= quo;
    end

    assign o_valid    = r_valid;
    assign o_x0       = r_x[0];
    assign o_x1       = r_x[1];
    assign o_x2       = r_x[2];
    assign o_x3       = r_x[3];
    assign o_singular = r_sing;

endmodule

### hw/rtl/lsc_store.sv
`timescale 1ns / 1ps

module lsc_store #(
    parameter int ELEM_WIDTH = lsc_pkg::ELEM_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we_mat,
    input  logic                               i_we_vec,
    input  logic [1:0]                         i_row,
    input  logic [1:0]                         i_col,
    input  logic signed [15:0]                 i_value,
    input  lsc_pkg::t_rd_req                   i_rd,
    output logic signed [lsc_pkg::VAL_W-1:0]   o_elem
);

    localparam int LW = (ELEM_WIDTH < 16) ? ELEM_WIDTH : 16;

    logic signed [ELEM_WIDTH-1:0] r_mat [16];
    logic signed [ELEM_WIDTH-1:0] r_vec [4];
    logic signed [LW-1:0]         wr_low;
    logic signed [ELEM_WIDTH-1:0] wr_val;
    logic signed [ELEM_WIDTH-1:0] rd_val;

    assign wr_low = i_value[LW-1:0];
    assign wr_val = ELEM_WIDTH'(wr_low);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_mat[i] <= '0;
            for (int i = 0; i < 4; i++) r_vec[i] <= '0;
        end else begin
            if (i_we_mat) r_mat[{i_row, i_col}] <= wr_val;
            if (i_we_vec) r_vec[i_row] <= wr_val;
        end
    end

    // column replaced by the right-hand side for the numerator determinants
    assign rd_val = (i_rd.repl_en && i_rd.col == i_rd.repl_col) ? r_vec[i_rd.row]
                                                               : r_mat[{i_rd.row, i_rd.col}];

    generate
        if (ELEM_WIDTH >= lsc_pkg::VAL_W) begin : g_trunc
            assign o_elem = rd_val[lsc_pkg::VAL_W-1:0];
        end else begin : g_ext
            assign o_elem = lsc_pkg::VAL_W'(rd_val);
        end
    endgenerate

endmodule

### hw/rtl/lsc_det.sv
`timescale 1ns / 1ps

module lsc_det (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [lsc_pkg::VAL_W-1:0]    i_elem,
    output logic [1:0]                          o_row,
    output logic [1:0]                          o_col,
    output logic                                o_done,
    output logic signed [lsc_pkg::DET_W-1:0]    o_det
);

    logic                               r_run;
    logic                               r_done;
    logic [4:0]                         r_perm;
    logic [2:0]                         r_step;
    logic signed [lsc_pkg::PROD_W-1:0]  r_prod;
    logic signed [lsc_pkg::DET_W-1:0]   r_acc;
    logic [8:0]                         perm;
    logic signed [47:0]                 mul_a;
    logic signed [lsc_pkg::PROD_W-1:0]  mul_res;
    logic signed [lsc_pkg::DET_W-1:0]   prod_ext;

    assign perm  = lsc_pkg::PERMS[r_perm];
    assign o_row = r_step[1:0];
    always_comb begin
        case (r_step[1:0])
            2'd0:    o_col = perm[7:6];
            2'd1:    o_col = perm[5:4];
            2'd2:    o_col = perm[3:2];
            default: o_col = perm[1:0];
        endcase
    end

    assign mul_a    = r_prod[47:0];
    assign mul_res  = mul_a * i_elem;
    assign prod_ext = lsc_pkg::DET_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_perm <= '0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_perm <= '0;
                r_step <= '0;
            end else if (r_run) begin
                if (r_step == 3'd4) begin
                    r_step <= '0;
                    if (r_perm == 5'(lsc_pkg::NUM_PERMS - 1)) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_perm <= r_perm + 5'd1;
                    end
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    // steps 0..3 build the product row by row, step 4 accumulates it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
        end else if (r_run) begin
            if (r_step == 3'd0) r_prod <= lsc_pkg::PROD_W'(i_elem);
            else if (r_step == 3'd4) r_acc <= perm[8] ? r_acc - prod_ext : r_acc + prod_ext;
            else r_prod <= mul_res;
        end
    end

    assign o_done = r_done;
    assign o_det  = r_acc;

endmodule

### hw/rtl/lsc_div.sv
`timescale 1ns / 1ps

module lsc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [lsc_pkg::DET_W-1:0]  i_num,
    input  logic signed [lsc_pkg::DET_W-1:0]  i_den,
    output logic                              o_done,
    output logic [31:0]                       o_quo
);

    localparam int DW = lsc_pkg::DET_W;
    localparam int NW = lsc_pkg::DIV_W;
    localparam int CW = $clog2(NW + 1);

    logic              r_run;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [NW-1:0]     r_dvd;
    logic [DW:0]       r_rem;
    logic [DW-1:0]     r_den;
    logic              r_neg;
    logic [32:0]       r_q;
    logic              r_big;
    logic [DW-1:0]     num_mag;
    logic [DW-1:0]     den_mag;
    logic [DW:0]       rem_sh;
    logic              ge;
    logic [32:0]       q_next;

    assign num_mag = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign den_mag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign rem_sh  = {r_rem[DW-1:0], r_dvd[NW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign q_next  = {r_q[31:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                if (r_cnt == CW'(NW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {num_mag, lsc_pkg::FRAC_W'(0)};
            r_rem <= '0;
            r_den <= den_mag;
            r_neg <= i_num[DW-1] ^ i_den[DW-1];
            r_q   <= '0;
            r_big <= 1'b0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[NW-2:0], 1'b0};
            r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
            if (!r_big) begin
                r_q   <= q_next;
                r_big <= q_next[32];
            end
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_quo = (r_big || r_q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : r_q[31:0];
        end else begin
            o_quo = (r_big || r_q > 33'h080000000) ? 32'h80000000 : 32'(-r_q[31:0]);
        end
    end

    assign o_done = r_done;

endmodule
